// File: hdl/deqs_pkg.sv
// ----------------------------------------------------------------------------
// deqs_pkg
// Shared types and constants for the double-ended queue with search.
// ----------------------------------------------------------------------------
package deqs_pkg;

    // Fixed widths of the item and result fields.
    localparam int OPCODE_W   = 3;
    localparam int ITEM_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int POSITION_W = 4;
    localparam int COUNT_W    = 5;

    // Default configuration of the top level.
    localparam int DEPTH_DEFAULT      = 16;
    localparam int VALUE_BITS_DEFAULT = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_SEARCH     = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

// File: hdl/deqs_ram.sv
// ----------------------------------------------------------------------------
// deqs_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module deqs_ram
    import deqs_pkg::*;
#(
    parameter int WIDTH = VALUE_BITS_DEFAULT,
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/double_ended_queue_with_search.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Bounded double-ended queue of values with a linear search by value.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH values in a RAM used as a circular buffer that
// is addressed from a front pointer. Each input item carries an opcode and a
// value: push front, push back, pop front, pop back, clear, or search. Every
// item produces exactly one result item with a status (done, empty, or full
// with the push dropped), a found flag and front-based position for searches,
// and the number of values held afterwards. Pushes, pops, clear, unused
// opcodes and a search of an empty queue finish in the cycle they are
// accepted, so those items can follow one another in every cycle while the
// result register is free. A search walks the held values through the single
// RAM read port, one compare per cycle, and stops at the first match; the
// input stalls during that walk and until the search result has been handed
// to the result register. The result sits in an output register, so a new
// item is taken while the previous result is still waiting, provided that
// result register is freed in the same cycle. The RAM is not cleared at
// reset; only slots holding live values are ever compared.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search
    import deqs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OPCODE_W-1:0]   opcode,
    input  logic [ITEM_W-1:0]     item_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic                  found,
    output logic [POSITION_W-1:0] position,
    output logic [COUNT_W-1:0]    entry_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_WIDE = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Sequencer and queue bookkeeping.
    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        front_reg, front_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    // Search walk.
    logic [VALUE_BITS-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]        scan_k_reg, scan_k_next;
    logic [CNT_W-1:0]        cmp_k_reg, cmp_k_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic                    hit_reg, hit_next;
    logic [CNT_W-1:0]        hit_k_reg, hit_k_next;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic                    found_reg, found_next;
    logic [POSITION_W-1:0]   position_reg, position_next;
    logic [COUNT_W-1:0]      entry_count_reg, entry_count_next;

    logic                    accept;
    logic                    out_free;
    op_t                     op;
    logic [VALUE_BITS+ITEM_W-1:0] val_wide;
    logic [VALUE_BITS-1:0]   in_key;
    logic [IDX_W-1:0]        slot_offset;
    logic [IDX_W:0]          slot_sum;
    logic [IDX_W-1:0]        slot_addr;
    logic [IDX_W-1:0]        front_dec;
    logic [IDX_W-1:0]        front_inc;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [VALUE_BITS-1:0]   rd_data;
    logic                    key_match;
    logic                    scan_last;

    // The input value is masked to the stored width.
    assign op       = op_t'(opcode);
    assign val_wide = {{VALUE_BITS{1'b0}}, item_value};
    assign in_key   = val_wide[VALUE_BITS-1:0];

    // One shared slot adder: front plus an offset, wrapped into the buffer.
    // During a search the offset is the walk index, otherwise it is the
    // count, which gives the back slot for a push at the back.
    assign slot_offset = (state_reg == S_SCAN) ? scan_k_reg[IDX_W-1:0]
                                               : count_reg[IDX_W-1:0];
    assign slot_sum    = {1'b0, front_reg} + {1'b0, slot_offset};
    assign slot_addr   = (slot_sum >= DEPTH_WIDE) ? IDX_W'(slot_sum - DEPTH_WIDE)
                                                  : slot_sum[IDX_W-1:0];

    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;

    // The single compare unit of the search walk.
    assign key_match = (rd_data == key_reg);
    assign scan_last = (cmp_k_reg == count_reg - CNT_W'(1));

    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;

    deqs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_key),
        .rd_addr (slot_addr),
        .rd_data (rd_data)
    );

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_SEARCH && count_reg != '0)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmp_valid_reg && (key_match || scan_last))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer: outputs. Items are taken only when idle and when the result
    // register can take the result of an item that finishes at once.
    always_comb
    begin
        in_stall = (state_reg != S_IDLE) || !out_free;
    end

    // Datapath.
    always_comb
    begin
        logic [STATUS_W-1:0]          st;
        logic [CNT_W+COUNT_W-1:0]     cnt_wide;
        logic [CNT_W+POSITION_W-1:0]  pos_wide;

        front_next       = front_reg;
        count_next       = count_reg;
        key_next         = key_reg;
        scan_k_next      = scan_k_reg;
        cmp_k_next       = cmp_k_reg;
        cmp_valid_next   = cmp_valid_reg;
        hit_next         = hit_reg;
        hit_k_next       = hit_k_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        found_next       = found_reg;
        position_next    = position_reg;
        entry_count_next = entry_count_reg;
        wr_en            = 1'b0;
        wr_addr          = slot_addr;
        st               = ST_DONE;
        cnt_wide         = '0;
        pos_wide         = {{POSITION_W{1'b0}}, hit_k_reg};

        if (accept)
        begin
            unique case (op)
                OP_PUSH_FRONT:
                begin
                    if (count_reg == FULL_COUNT)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (count_reg == FULL_COUNT)
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (count_reg == '0)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (count_reg == '0)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                OP_SEARCH:
                begin
                    if (count_reg == '0)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        key_next       = in_key;
                        scan_k_next    = '0;
                        cmp_valid_next = 1'b0;
                        hit_next       = 1'b0;
                        hit_k_next     = '0;
                    end
                end
                default:
                begin
                end
            endcase

            // Everything but a search of a non-empty queue finishes now.
            if (op != OP_SEARCH || count_reg == '0)
            begin
                cnt_wide         = {{COUNT_W{1'b0}}, count_next};
                out_valid_next   = 1'b1;
                status_next      = st;
                found_next       = 1'b0;
                position_next    = '0;
                entry_count_next = cnt_wide[COUNT_W-1:0];
            end
        end

        if (state_reg == S_SCAN)
        begin
            // Issue the next read while comparing the data of the last one.
            cmp_valid_next = (scan_k_reg < count_reg);
            cmp_k_next     = scan_k_reg;
            if (scan_k_reg < count_reg)
            begin
                scan_k_next = scan_k_reg + 1'b1;
            end
            if (cmp_valid_reg && key_match)
            begin
                hit_next   = 1'b1;
                hit_k_next = cmp_k_reg;
            end
        end

        if (state_reg == S_DONE && out_free)
        begin
            cnt_wide         = {{COUNT_W{1'b0}}, count_reg};
            out_valid_next   = 1'b1;
            status_next      = ST_DONE;
            found_next       = hit_reg;
            position_next    = pos_wide[POSITION_W-1:0];
            entry_count_next = cnt_wide[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        scan_k_reg      <= scan_k_next;
        cmp_k_reg       <= cmp_k_next;
        hit_reg         <= hit_next;
        hit_k_reg       <= hit_k_next;
        status_reg      <= status_next;
        found_reg       <= found_next;
        position_reg    <= position_next;
        entry_count_reg <= entry_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("held count exceeds the queue depth");

    // The queue state changes only when an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg) && $stable(front_reg))
        else $error("queue state changed without an accepted item");

    // The walk compares only live entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cmp_valid_reg) |-> cmp_k_reg < count_reg)
        else $error("search compared an entry beyond the held values");

    // A reported match lies within the held values.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && hit_reg) |-> hit_k_reg < count_reg)
        else $error("search match position beyond the held values");

    // A finished search is handed to the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("search result was not delivered");

endmodule
